/* src/odt_pkg.sv */
// ----------------------------------------------------------------------------
// odt_pkg
// Shared types and constants for the on/off delay timer bank.
// ----------------------------------------------------------------------------
package odt_pkg;

    localparam int REG_BITS       = 64;
    localparam int FIELD_BITS     = 16;
    localparam int FIELDS_PER_REG = 4;
    localparam int CH_IDX_BITS    = 3;
    localparam int CFG_IDX_BITS   = 2;
    localparam int LEVEL_BITS     = 8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ON_LOW   = 2'd0,
        CFG_ON_HIGH  = 2'd1,
        CFG_OFF_LOW  = 2'd2,
        CFG_OFF_HIGH = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        KIND_TRIGGER = 1'b0,
        KIND_TICK    = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [CH_IDX_BITS-1:0] channel;
        logic                   trigger_level;
    } item_t;

    typedef struct packed {
        logic tick;
        logic hit;
        logic level;
    } chan_cmd_t;

endpackage

/* src/on_off_delay_timer_bank_core.sv */
// ----------------------------------------------------------------------------
// on_off_delay_timer_bank_core
// Bank of combined on-delay / off-delay timers driven by trigger and tick items.
//
//   channel   signals                                    direction
//   input     s_valid s_ready s_kind s_channel s_trigger_level   in
//   result    m_valid m_ready m_output_levels m_fired             out
//   config    cfg_wr_en cfg_index cfg_wr_data                     in
//
// One item per cycle sustained while results are not stalled.
// An item sits in the input register, all channels update in one pass, and
// the result lands in the output register.
// A stalled result holds the output register; an empty input register takes
// one more item, then s_ready drops until the result leaves. Reset is
// synchronous and clears all timers.
// ----------------------------------------------------------------------------
module on_off_delay_timer_bank_core #(
    parameter int CHANNELS   = 8,
    parameter int DELAY_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [odt_pkg::CH_IDX_BITS-1:0]     s_channel,
    input  logic                                s_trigger_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [odt_pkg::LEVEL_BITS-1:0]      m_output_levels,
    output logic                                m_fired,
    input  logic                                cfg_wr_en,
    input  logic [odt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [odt_pkg::REG_BITS-1:0]        cfg_wr_data
);

    logic                                in_valid_reg;
    odt_pkg::item_t                      in_item_reg;
    logic                                out_valid_reg;
    logic [odt_pkg::LEVEL_BITS-1:0]      levels_reg;
    logic                                fired_reg;
    logic                                advance;
    logic [CHANNELS-1:0][DELAY_BITS-1:0] on_delay, off_delay;
    logic [CHANNELS-1:0]                 level_vec, fired_vec;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{kind: odt_pkg::kind_t'(s_kind), channel: s_channel,
                             trigger_level: s_trigger_level};
        end
    end

    odt_cfg #(
        .CHANNELS  (CHANNELS),
        .DELAY_BITS(DELAY_BITS)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .on_delay   (on_delay),
        .off_delay  (off_delay)
    );

    for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
        odt_pkg::chan_cmd_t cmd;

        assign cmd.tick  = in_item_reg.kind == odt_pkg::KIND_TICK;
        assign cmd.hit   = (in_item_reg.kind == odt_pkg::KIND_TRIGGER) &&
                           (in_item_reg.channel == odt_pkg::CH_IDX_BITS'(i));
        assign cmd.level = in_item_reg.trigger_level;

        odt_channel #(
            .DELAY_BITS(DELAY_BITS)
        ) u_channel (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (advance),
            .cmd       (cmd),
            .on_delay  (on_delay[i]),
            .off_delay (off_delay[i]),
            .level_next(level_vec[i]),
            .fired_next(fired_vec[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            levels_reg <= odt_pkg::LEVEL_BITS'(level_vec);
            fired_reg  <= |fired_vec;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_output_levels = levels_reg;
    assign m_fired         = fired_reg;

endmodule

/* src/odt_cfg.sv */
// ----------------------------------------------------------------------------
// odt_cfg
// Delay registers and per-channel delay extraction with saturation.
// ----------------------------------------------------------------------------
module odt_cfg #(
    parameter int CHANNELS   = 8,
    parameter int DELAY_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [odt_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [odt_pkg::REG_BITS-1:0]           cfg_wr_data,
    output logic [CHANNELS-1:0][DELAY_BITS-1:0]    on_delay,
    output logic [CHANNELS-1:0][DELAY_BITS-1:0]    off_delay
);

    localparam logic [odt_pkg::FIELD_BITS-1:0] DelayMax =
        odt_pkg::FIELD_BITS'((32'd1 << DELAY_BITS) - 32'd1);

    logic [odt_pkg::REG_BITS-1:0] on_low_reg, on_high_reg, off_low_reg, off_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_low_reg   <= '0;
            on_high_reg  <= '0;
            off_low_reg  <= '0;
            off_high_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (odt_pkg::cfg_idx_t'(cfg_index))
                odt_pkg::CFG_ON_LOW:   on_low_reg   <= cfg_wr_data;
                odt_pkg::CFG_ON_HIGH:  on_high_reg  <= cfg_wr_data;
                odt_pkg::CFG_OFF_LOW:  off_low_reg  <= cfg_wr_data;
                odt_pkg::CFG_OFF_HIGH: off_high_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
        localparam int Lsb = odt_pkg::FIELD_BITS * (i % odt_pkg::FIELDS_PER_REG);
        logic [odt_pkg::FIELD_BITS-1:0] on_field, off_field;

        if (i < odt_pkg::FIELDS_PER_REG) begin : g_low
            assign on_field  = on_low_reg[Lsb +: odt_pkg::FIELD_BITS];
            assign off_field = off_low_reg[Lsb +: odt_pkg::FIELD_BITS];
        end else begin : g_high
            assign on_field  = on_high_reg[Lsb +: odt_pkg::FIELD_BITS];
            assign off_field = off_high_reg[Lsb +: odt_pkg::FIELD_BITS];
        end

        assign on_delay[i]  = (on_field > DelayMax) ? DelayMax[DELAY_BITS-1:0]
                                                    : on_field[DELAY_BITS-1:0];
        assign off_delay[i] = (off_field > DelayMax) ? DelayMax[DELAY_BITS-1:0]
                                                     : off_field[DELAY_BITS-1:0];
    end

endmodule

/* src/odt_channel.sv */
// ----------------------------------------------------------------------------
// odt_channel
// One channel: output level plus on-delay and off-delay countdown timers.
// ----------------------------------------------------------------------------
module odt_channel #(
    parameter int DELAY_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  odt_pkg::chan_cmd_t     cmd,
    input  logic [DELAY_BITS-1:0]  on_delay,
    input  logic [DELAY_BITS-1:0]  off_delay,
    output logic                   level_next,
    output logic                   fired_next
);

    localparam logic [DELAY_BITS-1:0] One = DELAY_BITS'(1);

    logic                  level_reg, on_run_reg, off_run_reg;
    logic [DELAY_BITS-1:0] on_rem_reg, off_rem_reg;
    logic                  on_run_next, off_run_next;
    logic [DELAY_BITS-1:0] on_rem_next, off_rem_next;

    always_comb begin
        level_next   = level_reg;
        on_run_next  = on_run_reg;
        off_run_next = off_run_reg;
        on_rem_next  = on_rem_reg;
        off_rem_next = off_rem_reg;
        fired_next   = 1'b0;
        if (cmd.tick) begin
            if (on_run_reg) begin
                if (on_rem_reg <= One) begin
                    on_rem_next = '0;
                    on_run_next = 1'b0;
                    level_next  = 1'b1;
                    fired_next  = 1'b1;
                end else begin
                    on_rem_next = on_rem_reg - One;
                end
            end
            if (off_run_reg) begin
                if (off_rem_reg <= One) begin
                    off_rem_next = '0;
                    off_run_next = 1'b0;
                    level_next   = 1'b0;
                    fired_next   = 1'b1;
                end else begin
                    off_rem_next = off_rem_reg - One;
                end
            end
        end else if (cmd.hit) begin
            unique case ({cmd.level, level_reg})
                2'b00: begin
                    on_run_next = 1'b0;
                    on_rem_next = '0;
                end
                2'b01: begin
                    if (off_delay == '0) begin
                        level_next = 1'b0;
                    end else begin
                        off_rem_next = off_delay;
                        off_run_next = 1'b1;
                    end
                end
                2'b10: begin
                    if (on_delay == '0) begin
                        level_next = 1'b1;
                    end else begin
                        on_rem_next = on_delay;
                        on_run_next = 1'b1;
                    end
                end
                default: begin
                    off_run_next = 1'b0;
                    off_rem_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg   <= 1'b0;
            on_run_reg  <= 1'b0;
            off_run_reg <= 1'b0;
            on_rem_reg  <= '0;
            off_rem_reg <= '0;
        end else if (en) begin
            level_reg   <= level_next;
            on_run_reg  <= on_run_next;
            off_run_reg <= off_run_next;
            on_rem_reg  <= on_rem_next;
            off_rem_reg <= off_rem_next;
        end
    end

endmodule

/* src/odt_checker.sv */
// ----------------------------------------------------------------------------
// odt_checker
// Port-level checks for the timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module odt_checker #(
    parameter int CHANNELS = 8
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                s_kind,
    input logic [odt_pkg::CH_IDX_BITS-1:0]     s_channel,
    input logic                                s_trigger_level,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [odt_pkg::LEVEL_BITS-1:0]      m_output_levels,
    input logic                                m_fired
);

    localparam logic [odt_pkg::LEVEL_BITS-1:0] UsedMask =
        odt_pkg::LEVEL_BITS'((32'd1 << CHANNELS) - 32'd1);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_kind) && $stable(s_channel)
                                && $stable(s_trigger_level))
        else $error("waiting item changed before acceptance");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_output_levels) && $stable(m_fired))
        else $error("stalled result changed");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a waiting result");

    a_unused_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_output_levels & ~UsedMask) == '0)
        else $error("level reported on a channel that does not exist");

endmodule

bind on_off_delay_timer_bank_core odt_checker #(
    .CHANNELS(CHANNELS)
) u_odt_checker (.*);

/* sim/odt_level_checker.sv */
// ----------------------------------------------------------------------------
// odt_level_checker
// Watches the item and result channels of the on/off delay timer bank. It
// keeps its own copy of the delay registers and of every channel's timers,
// works out the output levels and the fired flag for each accepted item, and
// compares each result in order against them.
// ----------------------------------------------------------------------------
module odt_level_checker
    import odt_pkg::*;
#(
    parameter int CHANNELS   = 8,
    parameter int DELAY_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic                    s_kind,
    input  logic [CH_IDX_BITS-1:0]  s_channel,
    input  logic                    s_trigger_level,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [LEVEL_BITS-1:0]   m_output_levels,
    input  logic                    m_fired,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0]     cfg_wr_data,
    output int unsigned             outstanding,
    output int unsigned             mismatch_count
);

    localparam logic [FIELD_BITS-1:0] DELAY_MAX =
        FIELD_BITS'((64'd1 << DELAY_BITS) - 64'd1);

    typedef struct packed {
        logic [LEVEL_BITS-1:0] levels;
        logic                  fired;
    } level_report_t;

    logic [REG_BITS-1:0]   on_word_lo;
    logic [REG_BITS-1:0]   on_word_hi;
    logic [REG_BITS-1:0]   off_word_lo;
    logic [REG_BITS-1:0]   off_word_hi;
    logic [LEVEL_BITS-1:0] out_levels;
    logic [FIELD_BITS-1:0] on_left  [LEVEL_BITS];
    logic [FIELD_BITS-1:0] off_left [LEVEL_BITS];
    logic [LEVEL_BITS-1:0] on_busy;
    logic [LEVEL_BITS-1:0] off_busy;
    level_report_t         due_reports [$];

    initial mismatch_count = 0;

    function automatic logic [FIELD_BITS-1:0] delay_for(input logic [REG_BITS-1:0] lo_word,
                                                        input logic [REG_BITS-1:0] hi_word,
                                                        input int ch);
        logic [REG_BITS-1:0]   word;
        logic [FIELD_BITS-1:0] ticks;
        word  = (ch < FIELDS_PER_REG) ? lo_word : hi_word;
        ticks = word[FIELD_BITS*(ch % FIELDS_PER_REG) +: FIELD_BITS];
        return (ticks > DELAY_MAX) ? DELAY_MAX : ticks;
    endfunction

    // advance the timer bank by one item
    function automatic void apply_item(input kind_t kind, input logic [CH_IDX_BITS-1:0] ch,
                                       input logic level, output logic expired);
        logic [FIELD_BITS-1:0] ticks;
        expired = 1'b0;
        if (kind == KIND_TRIGGER) begin
            if (ch < CHANNELS) begin
                if (!level && !out_levels[ch]) begin
                    on_busy[ch] = 1'b0;
                    on_left[ch] = '0;
                end else if (!level) begin
                    ticks = delay_for(off_word_lo, off_word_hi, ch);
                    if (ticks == '0) begin
                        out_levels[ch] = 1'b0;
                    end else begin
                        off_left[ch] = ticks;
                        off_busy[ch] = 1'b1;
                    end
                end else if (!out_levels[ch]) begin
                    ticks = delay_for(on_word_lo, on_word_hi, ch);
                    if (ticks == '0) begin
                        out_levels[ch] = 1'b1;
                    end else begin
                        on_left[ch] = ticks;
                        on_busy[ch] = 1'b1;
                    end
                end else begin
                    off_busy[ch] = 1'b0;
                    off_left[ch] = '0;
                end
            end
        end else begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (on_busy[i]) begin
                    if (on_left[i] <= 1) begin
                        on_left[i]    = '0;
                        on_busy[i]    = 1'b0;
                        out_levels[i] = 1'b1;
                        expired       = 1'b1;
                    end else begin
                        on_left[i] = on_left[i] - 1'b1;
                    end
                end
                if (off_busy[i]) begin
                    if (off_left[i] <= 1) begin
                        off_left[i]   = '0;
                        off_busy[i]   = 1'b0;
                        out_levels[i] = 1'b0;
                        expired       = 1'b1;
                    end else begin
                        off_left[i] = off_left[i] - 1'b1;
                    end
                end
            end
        end
    endfunction

    always @(posedge aclk) begin
        level_report_t want;
        logic          expired;
        if (!aresetn) begin
            on_word_lo  = '0;
            on_word_hi  = '0;
            off_word_lo = '0;
            off_word_hi = '0;
            out_levels  = '0;
            on_busy     = '0;
            off_busy    = '0;
            for (int i = 0; i < LEVEL_BITS; i++) begin
                on_left[i]  = '0;
                off_left[i] = '0;
            end
            due_reports.delete();
            outstanding <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ON_LOW:   on_word_lo  = cfg_wr_data;
                    CFG_ON_HIGH:  on_word_hi  = cfg_wr_data;
                    CFG_OFF_LOW:  off_word_lo = cfg_wr_data;
                    CFG_OFF_HIGH: off_word_hi = cfg_wr_data;
                endcase
            end
            if (s_valid && s_ready) begin
                apply_item(kind_t'(s_kind), s_channel, s_trigger_level, expired);
                due_reports.push_back('{levels: out_levels, fired: expired});
            end
            if (m_valid && m_ready) begin
                if (due_reports.size() == 0) begin
                    $error("unexpected result: output_levels %h fired %b",
                           m_output_levels, m_fired);
                    mismatch_count++;
                end else begin
                    want = due_reports.pop_front();
                    if (m_output_levels !== want.levels) begin
                        $error("output_levels: expected %h, got %h",
                               want.levels, m_output_levels);
                        mismatch_count++;
                    end
                    if (m_fired !== want.fired) begin
                        $error("fired: expected %b, got %b", want.fired, m_fired);
                        mismatch_count++;
                    end
                end
            end
            outstanding <= due_reports.size();
        end
    end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the on/off delay timer bank with a directed run of trigger and tick
// items, then with random phases under several delay settings, with random
// stalls on both channels and one long result hold-off. A checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import odt_pkg::*;

    localparam int CHANNELS    = 8;
    localparam int DELAY_BITS  = 16;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 178;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;

    logic                    aclk;
    logic                    aresetn         = 1'b0;
    logic                    s_valid         = 1'b0;
    logic                    s_ready;
    logic                    s_kind          = KIND_TRIGGER;
    logic [CH_IDX_BITS-1:0]  s_channel       = '0;
    logic                    s_trigger_level = 1'b0;
    logic                    m_valid;
    logic                    m_ready         = 1'b0;
    logic [LEVEL_BITS-1:0]   m_output_levels;
    logic                    m_fired;
    logic                    cfg_wr_en       = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index       = CFG_ON_LOW;
    logic [REG_BITS-1:0]     cfg_wr_data     = '0;

    int unsigned outstanding;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned gap_odds = 0;
    bit          calm     = 1'b0;
    bit          hold_ask = 1'b0;
    logic        last_trigger [LEVEL_BITS];

    on_off_delay_timer_bank_core #(
        .CHANNELS   (CHANNELS),
        .DELAY_BITS (DELAY_BITS)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_channel       (s_channel),
        .s_trigger_level (s_trigger_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_output_levels (m_output_levels),
        .m_fired         (m_fired),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data)
    );

    odt_level_checker #(
        .CHANNELS   (CHANNELS),
        .DELAY_BITS (DELAY_BITS)
    ) level_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_channel       (s_channel),
        .s_trigger_level (s_trigger_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_output_levels (m_output_levels),
        .m_fired         (m_fired),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .outstanding     (outstanding),
        .mismatch_count  (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_ask) begin
                hold_ask = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic [REG_BITS-1:0] pack4(input logic [FIELD_BITS-1:0] d0,
                                                  input logic [FIELD_BITS-1:0] d1,
                                                  input logic [FIELD_BITS-1:0] d2,
                                                  input logic [FIELD_BITS-1:0] d3);
        return {d3, d2, d1, d0};
    endfunction

    function automatic logic [REG_BITS-1:0] short_delays();
        logic [REG_BITS-1:0] word;
        for (int i = 0; i < FIELDS_PER_REG; i++) begin
            word[FIELD_BITS*i +: FIELD_BITS] =
                ($urandom_range(0, 5) == 0) ? '0 : FIELD_BITS'($urandom_range(1, 4));
        end
        return word;
    endfunction

    task automatic send_item(input kind_t kind, input logic [CH_IDX_BITS-1:0] ch,
                             input logic level);
        if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_channel       <= ch;
        s_trigger_level <= level;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [REG_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_delays(input logic [REG_BITS-1:0] on_lo, input logic [REG_BITS-1:0] on_hi,
                               input logic [REG_BITS-1:0] off_lo,
                               input logic [REG_BITS-1:0] off_hi);
        write_reg(CFG_ON_LOW, on_lo);
        write_reg(CFG_ON_HIGH, on_hi);
        write_reg(CFG_OFF_LOW, off_lo);
        write_reg(CFG_OFF_HIGH, off_hi);
    endtask

    initial begin
        logic [CH_IDX_BITS-1:0] ch;
        logic                   level;
        for (int i = 0; i < LEVEL_BITS; i++) last_trigger[i] = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        load_delays(pack4(0, 2, 1, 3), pack4(1, 1, 1, 16'hFFFF),
                    pack4(0, 3, 1, 3), pack4(1, 1, 1, 16'hFFFF));
        send_item(KIND_TRIGGER, 0, 1'b1);
        send_item(KIND_TRIGGER, 0, 1'b0);
        send_item(KIND_TRIGGER, 1, 1'b1);
        send_item(KIND_TRIGGER, 3, 1'b1);
        send_item(KIND_TICK, 0, 1'b0);
        send_item(KIND_TRIGGER, 1, 1'b1);
        send_item(KIND_TICK, 7, 1'b1);
        send_item(KIND_TICK, 5, 1'b0);
        send_item(KIND_TRIGGER, 1, 1'b1);
        send_item(KIND_TRIGGER, 1, 1'b0);
        send_item(KIND_TRIGGER, 1, 1'b1);
        send_item(KIND_TICK, 0, 1'b0);
        send_item(KIND_TRIGGER, 1, 1'b0);
        repeat (3) send_item(KIND_TICK, 2, 1'b1);
        send_item(KIND_TRIGGER, 2, 1'b1);
        send_item(KIND_TRIGGER, 2, 1'b0);
        send_item(KIND_TICK, 0, 1'b0);
        send_item(KIND_TRIGGER, 7, 1'b1);
        send_item(KIND_TRIGGER, 3, 1'b0);
        drain();
        // zero off-delay clears at once while the running off timer keeps going
        write_reg(CFG_OFF_LOW, pack4(0, 3, 1, 0));
        send_item(KIND_TRIGGER, 3, 1'b0);
        send_item(KIND_TRIGGER, 3, 1'b1);
        repeat (3) send_item(KIND_TICK, 3, 1'b0);
        last_trigger[1] = 1'b0;
        last_trigger[2] = 1'b0;
        last_trigger[3] = 1'b1;
        last_trigger[7] = 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            gap_odds = (phase % 3 == 0) ? 0 : 3;
            calm     = (phase == PHASES - 1);
            case (phase)
                0:       load_delays('0, '0, '0, '0);
                1:       load_delays('1, '1, '1, '1);
                2:       load_delays({$urandom, $urandom}, {$urandom, $urandom},
                                     {$urandom, $urandom}, {$urandom, $urandom});
                default: load_delays(short_delays(), short_delays(),
                                     short_delays(), short_delays());
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 4 && n == 30) hold_ask = 1'b1;
                if (phase == 5 && n == PHASE_ITEMS / 2) drain();
                ch    = CH_IDX_BITS'($urandom_range(0, CHANNELS - 1));
                level = ($urandom_range(0, 3) == 0) ? 1'($urandom_range(0, 1))
                                                    : ~last_trigger[ch];
                if ($urandom_range(0, 1) == 0) begin
                    send_item(KIND_TICK, ch, level);
                end else begin
                    last_trigger[ch] = level;
                    send_item(KIND_TRIGGER, ch, level);
                end
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
